### sv/ufsd_pkg.sv
// ---------------------------------------------------------------------------
// ufsd_pkg - shared types and constants for the form body decoder
// Status and escape codes, buffer sizes, register indexes, hex digit decode.
// ---------------------------------------------------------------------------
`default_nettype none

package ufsd_pkg;

  localparam int KEY_BUFFER_BYTES   = 32;
  localparam int VALUE_BUFFER_BYTES = 65;
  localparam int MAX_BODY_BYTES     = 1024;

  localparam int KEY_LIMIT_W   = 5;
  localparam int VALUE_LIMIT_W = 7;
  localparam int BODY_LIMIT_W  = 11;
  localparam int PART_CNT_W    = 7;
  localparam int BYTE_CNT_W    = BODY_LIMIT_W + 1;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [KEY_LIMIT_W-1:0]   KEY_LIMIT_RST   = 5'd31;
  localparam logic [VALUE_LIMIT_W-1:0] VALUE_LIMIT_RST = 7'd64;
  localparam logic [BODY_LIMIT_W-1:0]  BODY_LIMIT_RST  = 11'd1024;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BODY_LIMIT  = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7e;

  typedef enum logic [1:0] {
    ST_FINE      = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### sv/url_form_stream_decoder.sv
// ---------------------------------------------------------------------------
// url_form_stream_decoder - streaming form-urlencoded body decoder
// Splits a raw body into key/value pairs and percent-decodes each character.
// ---------------------------------------------------------------------------
// One raw body byte is taken per cycle unless the output stalls, and gives
// exactly one result, captured in the output register at the transfer; the
// decode state updates in that same cycle, so bytes stream back to back at
// one per clock. s_axis_tready follows m_axis_tready whenever a result is held,
// so the only stall comes from downstream. Limits must be written on the cfg
// channel between bodies (not enforced by the block); index 3 is ignored.
`default_nettype none

module url_form_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] form_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] decoded_char, [8] pair_end,
                                           // [10:9] status, [15:11] zero
  output logic [1:0]       m_axis_tuser,   // [0] char_valid, [1] in_value
  output logic             m_axis_tlast,   // body_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ufsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ufsd_pkg::BODY_LIMIT_W-1:0] cfg_data
);
  import ufsd_pkg::*;

  logic [KEY_LIMIT_W-1:0]   key_limit;
  logic [VALUE_LIMIT_W-1:0] value_limit;
  logic [BODY_LIMIT_W-1:0]  body_limit;

  logic                  in_value_part, in_value_part_next;
  esc_t                  escape_step, escape_step_next;
  logic [3:0]            high_nibble, high_nibble_next;
  logic [PART_CNT_W-1:0] part_count, part_count_next;
  logic                  pair_started, pair_started_next;
  logic [BYTE_CNT_W-1:0] byte_count, byte_count_next;
  status_t               error_code, error_code_next;

  logic       cv, iv, pe;
  logic [7:0] ch;

  logic [BODY_LIMIT_W-1:0] blim;
  logic [PART_CNT_W-1:0]   key_lim_eff, value_lim_eff, plim;
  logic                    accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign blim = (32'(body_limit) > MAX_BODY_BYTES) ?
                BODY_LIMIT_W'(MAX_BODY_BYTES) : body_limit;
  assign key_lim_eff = (32'(key_limit) > KEY_BUFFER_BYTES - 1) ?
                       PART_CNT_W'(KEY_BUFFER_BYTES - 1) : PART_CNT_W'(key_limit);
  assign value_lim_eff = (32'(value_limit) > VALUE_BUFFER_BYTES - 1) ?
                         PART_CNT_W'(VALUE_BUFFER_BYTES - 1) : value_limit;
  assign plim = in_value_part ? value_lim_eff : key_lim_eff;

  always_comb begin
    logic       have;
    logic       amp;
    logic [7:0] v;
    hex_t       h;
    have = 1'b0;
    amp  = 1'b0;
    v    = 8'd0;
    h    = hex_digit(s_axis_tdata);
    cv   = 1'b0;
    ch   = 8'd0;
    iv   = 1'b0;
    pe   = 1'b0;

    in_value_part_next = in_value_part;
    escape_step_next   = escape_step;
    high_nibble_next   = high_nibble;
    part_count_next    = part_count;
    pair_started_next  = pair_started;
    byte_count_next    = byte_count;
    error_code_next    = error_code;

    if (byte_count <= BYTE_CNT_W'(blim)) begin
      byte_count_next = byte_count + 1'b1;
    end
    if (byte_count_next > BYTE_CNT_W'(blim)) begin
      error_code_next = ST_TOO_LARGE;
    end

    if (error_code_next == ST_FINE) begin
      if (escape_step != ESC_NONE) begin
        if (!h.ok) begin
          error_code_next = ST_MALFORMED;
        end else if (escape_step == ESC_HIGH) begin
          high_nibble_next = h.val;
          escape_step_next = ESC_LOW;
        end else begin
          v                = {high_nibble, h.val};
          escape_step_next = ESC_NONE;
          have             = 1'b1;
        end
      end else if (s_axis_tdata == CH_AMP) begin
        amp = 1'b1;
        if (pair_started && in_value_part && part_count != '0) begin
          pe                 = 1'b1;
          in_value_part_next = 1'b0;
          part_count_next    = '0;
          pair_started_next  = 1'b0;
          if (s_axis_tlast) begin
            error_code_next = ST_MALFORMED;
          end
        end else begin
          error_code_next = ST_MALFORMED;
        end
      end else if (s_axis_tdata == CH_EQUAL && !in_value_part) begin
        pair_started_next = 1'b1;
        if (part_count == '0) begin
          error_code_next = ST_MALFORMED;
        end else begin
          in_value_part_next = 1'b1;
          part_count_next    = '0;
        end
      end else if (s_axis_tdata == CH_PERCENT) begin
        pair_started_next = 1'b1;
        escape_step_next  = ESC_HIGH;
      end else begin
        pair_started_next = 1'b1;
        v    = (s_axis_tdata == CH_PLUS) ? CH_SPACE : s_axis_tdata;
        have = 1'b1;
      end

      if (have && error_code_next == ST_FINE) begin
        if (v < CH_SPACE || v > CH_TILDE || part_count_next >= plim) begin
          error_code_next = ST_MALFORMED;
        end else begin
          cv              = 1'b1;
          ch              = v;
          iv              = in_value_part_next;
          part_count_next = part_count_next + 1'b1;
        end
      end

      if (s_axis_tlast && !amp && error_code_next == ST_FINE) begin
        if (pair_started_next && in_value_part_next && part_count_next != '0 &&
            escape_step_next == ESC_NONE) begin
          pe = 1'b1;
        end else begin
          error_code_next = ST_MALFORMED;
        end
      end
    end

    if (error_code_next != ST_FINE) begin
      cv = 1'b0;
      ch = 8'd0;
      iv = 1'b0;
      if (!(pe && s_axis_tlast && error_code_next == ST_MALFORMED)) begin
        pe = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit   <= KEY_LIMIT_RST;
      value_limit <= VALUE_LIMIT_RST;
      body_limit  <= BODY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LIMIT:   key_limit   <= cfg_data[KEY_LIMIT_W-1:0];
        REG_VALUE_LIMIT: value_limit <= cfg_data[VALUE_LIMIT_W-1:0];
        REG_BODY_LIMIT:  body_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value_part <= 1'b0;
      escape_step   <= ESC_NONE;
      high_nibble   <= 4'd0;
      part_count    <= '0;
      pair_started  <= 1'b0;
      byte_count    <= '0;
      error_code    <= ST_FINE;
    end else if (accept) begin
      if (s_axis_tlast) begin
        in_value_part <= 1'b0;
        escape_step   <= ESC_NONE;
        high_nibble   <= 4'd0;
        part_count    <= '0;
        pair_started  <= 1'b0;
        byte_count    <= '0;
        error_code    <= ST_FINE;
      end else begin
        in_value_part <= in_value_part_next;
        escape_step   <= escape_step_next;
        high_nibble   <= high_nibble_next;
        part_count    <= part_count_next;
        pair_started  <= pair_started_next;
        byte_count    <= byte_count_next;
        error_code    <= error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {5'd0, error_code_next, pe, ch};
      m_axis_tuser <= {iv, cv};
      m_axis_tlast <= s_axis_tlast;
    end
  end

endmodule

`default_nettype wire

### sv/ufsd_checker.sv
// ---------------------------------------------------------------------------
// ufsd_checker - port-level checks for the form body decoder
// Watches the result stream and flags inconsistent flags and status.
// ---------------------------------------------------------------------------
`default_nettype none

module ufsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import ufsd_pkg::*;

  // stalled transfer holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_char_fine: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[10:9] == ST_FINE &&
      m_axis_tdata[7:0] >= CH_SPACE && m_axis_tdata[7:0] <= CH_TILDE)
    else $error("character given with bad status or unprintable");

  a_value_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("in_value without character");

  // pair_end under an error only for a trailing '&' on the last byte
  a_pair_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] && m_axis_tdata[10:9] != ST_FINE |->
      m_axis_tlast && m_axis_tdata[10:9] == ST_MALFORMED)
    else $error("pair_end with unexpected status");

endmodule

bind url_form_stream_decoder ufsd_checker u_ufsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench - self-checking bench for url_form_stream_decoder
// Streams form bodies (directed corner cases, then random well-formed and
// damaged bodies) through the decoder under several limit settings with
// random gaps on both stream sides. Every output transfer is checked field
// by field against an in-bench decoder model.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ufsd_pkg::*;

  localparam int TARGET_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } raw_byte_t;

  typedef struct {
    logic       char_valid;
    logic [7:0] ch;
    logic       in_value;
    logic       pair_end;
    logic       body_end;
    status_t    status;
  } form_result_t;

  typedef enum int {
    FLAW_BYTE, FLAW_TRAIL_AMP, FLAW_EMPTY_PAIR, FLAW_CUT_ESC, FLAW_UNPRINTABLE,
    FLAW_BAD_ESC, FLAW_NO_EQUAL, FLAW_EMPTY_KEY, FLAW_EMPTY_VALUE
  } flaw_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = 8'd0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;
  logic [1:0]              m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_KEY_LIMIT;
  logic [BODY_LIMIT_W-1:0] cfg_data = '0;

  url_form_stream_decoder dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // decoder model state
  logic [KEY_LIMIT_W-1:0]   lim_key   = KEY_LIMIT_RST;
  logic [VALUE_LIMIT_W-1:0] lim_value = VALUE_LIMIT_RST;
  logic [BODY_LIMIT_W-1:0]  lim_body  = BODY_LIMIT_RST;
  logic    dec_in_value = 1'b0;
  esc_t    dec_esc = ESC_NONE;
  logic [3:0] dec_high_nib = 4'd0;
  int      dec_part_cnt = 0;
  logic    dec_pair_started = 1'b0;
  int      dec_byte_cnt = 0;
  status_t dec_status = ST_FINE;

  raw_byte_t    bytes_to_send[$];
  form_result_t expected_results[$];
  logic [7:0]   body_buf[$];
  int total_items = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_hold = 0;
  logic calm = 1'b0;
  form_result_t want, got;

  function automatic logic pair_complete();
    return dec_pair_started && dec_in_value && dec_part_cnt > 0 && dec_esc == ESC_NONE;
  endfunction

  function automatic form_result_t decode_byte(input logic [7:0] b, input logic last);
    form_result_t r;
    int   blim, plim, nib, v;
    logic have, amp;
    r.char_valid = 1'b0;
    r.ch         = 8'd0;
    r.in_value   = 1'b0;
    r.pair_end   = 1'b0;
    r.body_end   = last;
    blim = (lim_body > MAX_BODY_BYTES) ? MAX_BODY_BYTES : int'(lim_body);
    if (dec_byte_cnt <= blim) dec_byte_cnt++;
    if (dec_byte_cnt > blim) dec_status = ST_TOO_LARGE;
    if (dec_status == ST_FINE) begin
      have = 1'b0;
      amp  = 1'b0;
      v    = 0;
      if (dec_esc != ESC_NONE) begin
        nib = -1;
        if (b >= 8'h30 && b <= 8'h39) nib = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66) nib = b - 8'h61 + 10;
        else if (b >= 8'h41 && b <= 8'h46) nib = b - 8'h41 + 10;
        if (nib < 0) begin
          dec_status = ST_MALFORMED;
        end else if (dec_esc == ESC_HIGH) begin
          dec_high_nib = nib[3:0];
          dec_esc = ESC_LOW;
        end else begin
          v = {dec_high_nib, nib[3:0]};
          dec_esc = ESC_NONE;
          have = 1'b1;
        end
      end else if (b == CH_AMP) begin
        amp = 1'b1;
        if (pair_complete()) begin
          r.pair_end = 1'b1;
          dec_in_value = 1'b0;
          dec_part_cnt = 0;
          dec_pair_started = 1'b0;
          if (last) dec_status = ST_MALFORMED;
        end else begin
          dec_status = ST_MALFORMED;
        end
      end else if (b == CH_EQUAL && !dec_in_value) begin
        dec_pair_started = 1'b1;
        if (dec_part_cnt == 0) begin
          dec_status = ST_MALFORMED;
        end else begin
          dec_in_value = 1'b1;
          dec_part_cnt = 0;
        end
      end else if (b == CH_PERCENT) begin
        dec_pair_started = 1'b1;
        dec_esc = ESC_HIGH;
      end else begin
        dec_pair_started = 1'b1;
        v = (b == CH_PLUS) ? int'(CH_SPACE) : int'(b);
        have = 1'b1;
      end
      if (have && dec_status == ST_FINE) begin
        if (dec_in_value)
          plim = (lim_value > VALUE_BUFFER_BYTES - 1) ? VALUE_BUFFER_BYTES - 1
                                                      : int'(lim_value);
        else
          plim = (lim_key > KEY_BUFFER_BYTES - 1) ? KEY_BUFFER_BYTES - 1
                                                  : int'(lim_key);
        if (v < CH_SPACE || v > CH_TILDE || dec_part_cnt >= plim) begin
          dec_status = ST_MALFORMED;
        end else begin
          r.char_valid = 1'b1;
          r.ch = v[7:0];
          r.in_value = dec_in_value;
          dec_part_cnt++;
        end
      end
      if (last && !amp && dec_status == ST_FINE) begin
        if (pair_complete()) r.pair_end = 1'b1;
        else dec_status = ST_MALFORMED;
      end
    end
    if (dec_status != ST_FINE) begin
      r.char_valid = 1'b0;
      r.ch = 8'd0;
      r.in_value = 1'b0;
      if (!(r.pair_end && last && dec_status == ST_MALFORMED)) r.pair_end = 1'b0;
    end
    r.status = dec_status;
    if (last) begin
      dec_in_value = 1'b0;
      dec_esc = ESC_NONE;
      dec_high_nib = 4'd0;
      dec_part_cnt = 0;
      dec_pair_started = 1'b0;
      dec_byte_cnt = 0;
      dec_status = ST_FINE;
    end
    return r;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(decode_byte(s_axis_tdata, s_axis_tlast));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= bytes_to_send[0].b;
          s_axis_tlast  <= bytes_to_send[0].last;
          void'(bytes_to_send.pop_front());
          send_gap = gap_length();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_hold = 0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_hold = gap_length();
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.char_valid = m_axis_tuser[0];
      got.in_value   = m_axis_tuser[1];
      got.ch         = m_axis_tdata[7:0];
      got.pair_end   = m_axis_tdata[8];
      got.status     = status_t'(m_axis_tdata[10:9]);
      got.body_end   = m_axis_tlast;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transfer: cv=%0d ch=%02h iv=%0d pe=%0d last=%0d st=%0d",
                   got.char_valid, got.ch, got.in_value, got.pair_end, got.body_end,
                   got.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.char_valid !== want.char_valid || got.ch !== want.ch ||
            got.in_value !== want.in_value || got.pair_end !== want.pair_end ||
            got.body_end !== want.body_end || got.status !== want.status) begin
          if (mismatches < 10)
            $display({"mismatch: exp cv=%0d ch=%02h iv=%0d pe=%0d last=%0d st=%0d,",
                      " got cv=%0d ch=%02h iv=%0d pe=%0d last=%0d st=%0d"},
                     want.char_valid, want.ch, want.in_value, want.pair_end,
                     want.body_end, want.status, got.char_valid, got.ch,
                     got.in_value, got.pair_end, got.body_end, got.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // sampled between edges so queue and handshake updates have settled
  task automatic wait_drain();
    @(negedge clk);
    while (bytes_to_send.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[BODY_LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_LIMIT:   lim_key   = val[KEY_LIMIT_W-1:0];
      REG_VALUE_LIMIT: lim_value = val[VALUE_LIMIT_W-1:0];
      REG_BODY_LIMIT:  lim_body  = val[BODY_LIMIT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_body(input logic close);
    int i;
    for (i = 0; i < body_buf.size(); i++) begin
      bytes_to_send.push_back('{b: body_buf[i], last: close && i == body_buf.size() - 1});
      total_items++;
    end
  endtask

  task automatic set_text(input string s);
    int i;
    body_buf.delete();
    for (i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic add_escape(input logic [7:0] v);
    body_buf.push_back(CH_PERCENT);
    body_buf.push_back(hex_char(v[7:4]));
    body_buf.push_back(hex_char(v[3:0]));
  endtask

  task automatic add_part(input int lim, input logic is_value);
    int n, r, k;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 85) n = $urandom_range(1, lim < 6 ? lim : 6);
    else if (r < 95) n = lim;
    else n = lim + 1;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        body_buf.push_back(CH_PLUS);
      end else if (r < 40) begin
        add_escape(8'($urandom_range(8'h20, 8'h7e)));
      end else begin
        do c = 8'($urandom_range(8'h20, 8'h7e));
        while (c == CH_PERCENT || c == CH_AMP || c == CH_PLUS ||
               (c == CH_EQUAL && !is_value));
        body_buf.push_back(c);
      end
    end
  endtask

  task automatic build_body();
    int r, n, p;
    logic [7:0] c;
    body_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) body_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 3);
      for (p = 0; p < n; p++) begin
        if (p > 0) body_buf.push_back(CH_AMP);
        add_part(lim_key, 1'b0);
        body_buf.push_back(CH_EQUAL);
        add_part(lim_value, 1'b1);
      end
      if (r >= 70) begin
        case (flaw_t'($urandom_range(0, 8)))
          FLAW_BYTE:
            body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom_range(0, 255));
          FLAW_TRAIL_AMP: body_buf.push_back(CH_AMP);
          FLAW_EMPTY_PAIR: body_buf.insert($urandom_range(0, 1) ? 0 : body_buf.size(), CH_AMP);
          FLAW_CUT_ESC: begin
            body_buf.push_back(CH_PERCENT);
            if ($urandom_range(0, 1)) body_buf.push_back(hex_char(4'($urandom_range(0, 15))));
          end
          FLAW_UNPRINTABLE:
            add_escape($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h1f))
                                            : 8'($urandom_range(8'h7f, 8'hff)));
          FLAW_BAD_ESC: begin
            body_buf.push_back(CH_PERCENT);
            if ($urandom_range(0, 1)) body_buf.push_back(hex_char(4'($urandom_range(0, 15))));
            case ($urandom_range(0, 2))
              0: c = CH_AMP;
              1: c = CH_EQUAL;
              default: begin
                do c = 8'($urandom_range(0, 255));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66));
              end
            endcase
            body_buf.push_back(c);
            body_buf.push_back(8'h78);
          end
          FLAW_NO_EQUAL: begin
            body_buf.delete();
            add_part(lim_key, 1'b0);
          end
          FLAW_EMPTY_KEY: body_buf.insert(0, CH_EQUAL);
          FLAW_EMPTY_VALUE: begin
            body_buf.delete();
            add_part(lim_key, 1'b0);
            body_buf.push_back(CH_EQUAL);
          end
          default: ;
        endcase
      end
    end
  endtask

  function automatic int pick_limit(input int lo, input int hi, input int rlo, input int rhi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(rlo, rhi);
  endfunction

  initial begin
    int phase, target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed bodies at reset limits; the first one is paused mid-body
    set_text("%4a=+~&b");
    push_body(1'b0);
    wait_drain();
    set_text("==");
    push_body(1'b1);
    set_text("k");    push_body(1'b1);
    set_text("=");    push_body(1'b1);
    set_text("a=");   push_body(1'b1);
    set_text("a=b&"); push_body(1'b1);
    set_text("&");    push_body(1'b1);
    set_text("a=%");  push_body(1'b1);
    body_buf.delete();
    body_buf.push_back(8'h00);
    push_body(1'b1);
    set_text("a=");
    body_buf.push_back(8'hff);
    push_body(1'b1);

    phase = 0;
    while (total_items < TARGET_ITEMS) begin
      wait_drain();
      repeat (3) @(posedge clk);
      case (phase)
        0: begin
          write_reg(REG_KEY_LIMIT, 1);
          write_reg(REG_VALUE_LIMIT, 1);
          write_reg(REG_BODY_LIMIT, 1024);
        end
        1: begin
          write_reg(REG_KEY_LIMIT, 31);
          write_reg(REG_VALUE_LIMIT, 64);
          write_reg(REG_BODY_LIMIT, 1);
        end
        default: begin
          write_reg(REG_KEY_LIMIT, pick_limit(1, 31, 2, 12));
          write_reg(REG_VALUE_LIMIT, pick_limit(1, 64, 2, 16));
          write_reg(REG_BODY_LIMIT, pick_limit(1, 1024, 8, 80));
        end
      endcase
      calm = (phase == 2);
      target = total_items + ((phase == 1) ? 40 : 90);
      while (total_items < target) begin
        build_body();
        push_body(1'b1);
      end
      phase++;
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/ufsd_pkg.sv
sv/url_form_stream_decoder.sv
sv/ufsd_checker.sv
tb/testbench.sv
